### design/lse_pkg.sv
// Shared constants and types for the Laguerre sequence evaluator.
package lse_pkg;

    localparam int X_W     = 32;                 // argument, Q8.24
    localparam int TOP_W   = 7;                  // requested order, signed
    localparam int ORD_W   = 6;                  // order index
    localparam int VAL_W   = 64;                 // values, Q24.40
    localparam int FRAC_W  = 40;
    localparam int X_SHIFT = FRAC_W - 24;        // Q8.24 -> Q24.40
    localparam int HALF_W  = VAL_W / 2;          // multiplier operand width
    localparam int ACC_W   = 2 * VAL_W;          // full product
    localparam int KP_W    = VAL_W + ORD_W;      // k * |L[k-1]|

    localparam int MAX_ORDER = 63;

    // Divider: a row of cells, one numerator digit each
    localparam int DIG_W   = 8;
    localparam int N_CELLS = 9;
    localparam int NUM_W   = N_CELLS * DIG_W;    // numerator magnitude
    localparam int M_W     = NUM_W + 1;          // signed numerator
    localparam int DVSR_W  = 7;                  // divisor k+1

    localparam logic [VAL_W-1:0] ONE_VAL   = VAL_W'(1) << FRAC_W;
    localparam logic [VAL_W-1:0] ALPHA_INC = VAL_W'(2) << FRAC_W;
    localparam logic [VAL_W-1:0] ALPHA_1   = ONE_VAL + ALPHA_INC;
    localparam logic [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (FRAC_W - 1);

    typedef struct packed {
        logic              go;
        logic [NUM_W-1:0]  mag;
        logic [DVSR_W-1:0] dvsr;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

### design/lse_div_cell.sv
// One divider cell: eight restoring steps on its numerator digit.
module lse_div_cell
    import lse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [DIG_W-1:0]  i_dig,
    input  logic              i_tok,
    input  logic [DVSR_W-1:0] i_rem,
    input  logic [DVSR_W-1:0] i_dvsr,
    output logic              o_tok,
    output logic [DVSR_W-1:0] o_rem,
    output logic [DIG_W-1:0]  o_quo
);

    logic              r_tok;
    logic [DIG_W-1:0]  r_dig;
    logic [DIG_W-1:0]  r_quo;
    logic [DVSR_W-1:0] r_rem;
    logic [DIG_W-1:0]  w_quo;
    logic [DVSR_W-1:0] w_rem;

    always_comb begin
        logic [DVSR_W:0]   v_t;
        logic [DVSR_W-1:0] v_rem;
        v_rem = i_rem;
        w_quo = '0;
        for (int b = DIG_W - 1; b >= 0; b--) begin
            v_t = {v_rem, r_dig[b]};
            if (v_t >= {1'b0, i_dvsr}) begin
                w_quo[b] = 1'b1;
                v_t      = v_t - {1'b0, i_dvsr};
            end
            v_rem = v_t[DVSR_W-1:0];
        end
        w_rem = v_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
        if (i_load) begin
            r_dig <= i_dig;
        end
        if (i_tok) begin
            r_quo <= w_quo;
            r_rem <= w_rem;
        end
    end

    assign o_tok = r_tok;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

### design/lse_divider.sv
// Divider by a small integer: the remainder ripples down a row of digit cells.
module lse_divider
    import lse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_start;
    logic [DVSR_W-1:0] r_dvsr;
    logic [N_CELLS:0]  w_tok;
    logic [DVSR_W-1:0] w_rem [N_CELLS+1];
    logic [DIG_W-1:0]  w_quo [N_CELLS];
    logic [NUM_W-1:0]  w_quo_flat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= i_req.go;
        end
        if (i_req.go) begin
            r_dvsr <= i_req.dvsr;
        end
    end

    assign w_tok[0] = r_start;
    assign w_rem[0] = '0;

    for (genvar j = 0; j < N_CELLS; j++) begin : g_cell
        lse_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_load (i_req.go),
            .i_dig  (i_req.mag[NUM_W-1-j*DIG_W -: DIG_W]),
            .i_tok  (w_tok[j]),
            .i_rem  (w_rem[j]),
            .i_dvsr (r_dvsr),
            .o_tok  (w_tok[j+1]),
            .o_rem  (w_rem[j+1]),
            .o_quo  (w_quo[j])
        );
    end

    always_comb begin
        w_quo_flat = '0;
        for (int j = 0; j < N_CELLS; j++) begin
            w_quo_flat[NUM_W-1-j*DIG_W -: DIG_W] = w_quo[j];
        end
    end

    assign o_rsp.done = w_tok[N_CELLS];
    assign o_rsp.quo  = w_quo_flat;

endmodule

### design/laguerre_sequence_eval.sv
// Laguerre polynomial sequence evaluator, top level.
//
// Input channel: one beat carries x (i_arg_x, signed Q8.24) and the highest
// order n (i_top_order, signed). The block answers with L0(x) .. Ln(x) on the
// output channel, one beat per order in increasing order, each value signed
// Q24.40 with its order, a sticky saturation flag and a last flag on order n.
// A negative order is taken and yields no beat; orders above 63 are clamped.
// One run is in flight at a time: o_in_stall is high from the accepting edge
// until the last beat of the run has been placed in the output register.
// After the accept, L0 and L1 are placed in turn. Every further order passes
// through placing the previous beat, alpha*L[k] (four passes of the 32x32
// multiplier and a final add), rounding, combining, taking the magnitude and
// the divider, whose nine cells each settle one 8-bit quotient digit in turn.
// A stalled beat holds; the run waits to place its next beat until the stalled one is taken.
// Reset is synchronous, active low, and returns to idle with no beat pending.
module laguerre_sequence_eval
    import lse_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [X_W-1:0]   i_arg_x,
    input  logic signed [TOP_W-1:0] i_top_order,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ORD_W-1:0]        o_order_index,
    output logic signed [VAL_W-1:0] o_poly_value,
    output logic                    o_saturated,
    output logic                    o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_MUL,
        S_RND,
        S_NUM,
        S_MAG,
        S_DIV
    } t_state;

    localparam logic [2:0] MUL_PASSES = 3'd4;

    t_state           r_state;
    logic [ORD_W-1:0] r_n;
    logic [ORD_W-1:0] r_idx;
    logic [VAL_W-1:0] r_alpha;
    logic [VAL_W-1:0] r_prev;
    logic [VAL_W-1:0] r_cur;
    logic             r_sat;
    logic [VAL_W-1:0] r_amag;
    logic [VAL_W-1:0] r_cmag;
    logic [VAL_W-1:0] r_pmag;
    logic             r_neg_p;
    logic             r_neg_q;
    logic             r_neg_n;
    logic [2:0]       r_mc;
    logic [VAL_W-1:0] r_prod;
    logic [ACC_W-1:0] r_acc;
    logic [KP_W-1:0]  r_kp;
    logic [NUM_W-1:0] r_pm;
    logic [M_W-1:0]   r_m;

    logic             r_out_valid;
    logic [ORD_W-1:0] r_out_idx;
    logic [VAL_W-1:0] r_out_val;
    logic             r_out_sat;
    logic             r_out_last;

    logic [VAL_W-1:0]  w_xs;
    logic [ORD_W-1:0]  w_top;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_out_last;
    logic [HALF_W-1:0] w_a_h;
    logic [HALF_W-1:0] w_b_h;
    logic [VAL_W-1:0]  w_prod;
    logic [1:0]        w_prev_sel;
    logic [ACC_W-1:0]  w_acc_add;
    logic [ACC_W-1:0]  w_rnd_sum;
    logic [M_W-1:0]    w_pm_s;
    logic [M_W-1:0]    w_kp_s;
    logic [DVSR_W-1:0] w_dvsr;
    logic [M_W-1:0]    w_half;
    logic [NUM_W-1:0]  w_mag;
    logic              w_big_pos;
    logic              w_big_neg;
    logic              w_clamp;
    logic [VAL_W-1:0]  w_next;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    // x in Q24.40
    assign w_xs  = {{(VAL_W-X_W-X_SHIFT){i_arg_x[X_W-1]}}, i_arg_x, {X_SHIFT{1'b0}}};
    assign w_top = (i_top_order[TOP_W-1:0] > TOP_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
                                                                 : i_top_order[ORD_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = (r_state == S_PUT) && w_out_free;
    assign w_out_last = (r_idx == r_n);

    // Partial products of |alpha| * |L[k]|, low halves first
    assign w_a_h      = r_mc[1] ? r_amag[VAL_W-1:HALF_W] : r_amag[HALF_W-1:0];
    assign w_b_h      = r_mc[0] ? r_cmag[VAL_W-1:HALF_W] : r_cmag[HALF_W-1:0];
    assign w_prod     = {{HALF_W{1'b0}}, w_a_h} * {{HALF_W{1'b0}}, w_b_h};
    assign w_prev_sel = 2'(r_mc - 3'd1);

    always_comb begin
        case (w_prev_sel)
            2'b00:   w_acc_add = ACC_W'(r_prod);
            2'b11:   w_acc_add = ACC_W'(r_prod) << VAL_W;
            default: w_acc_add = ACC_W'(r_prod) << HALF_W;
        endcase
    end

    assign w_rnd_sum = r_acc + RND_HALF;
    assign w_pm_s    = {1'b0, r_pm};
    assign w_kp_s    = M_W'(r_kp);

    // Numerator magnitude plus half the divisor, for round to nearest
    assign w_dvsr = DVSR_W'(r_idx) + DVSR_W'(1);
    assign w_half = M_W'(w_dvsr >> 1);
    assign w_mag  = r_m[M_W-1] ? NUM_W'(w_half - r_m) : NUM_W'(r_m + w_half);

    assign w_div_req.go   = (r_state == S_MAG);
    assign w_div_req.mag  = w_mag;
    assign w_div_req.dvsr = w_dvsr;

    lse_divider u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // A negative result may reach -2^63 exactly
    assign w_big_pos = |w_div_rsp.quo[NUM_W-1:VAL_W-1];
    assign w_big_neg = (|w_div_rsp.quo[NUM_W-1:VAL_W])
                    || (w_div_rsp.quo[VAL_W-1] && (|w_div_rsp.quo[VAL_W-2:0]));
    assign w_clamp   = r_neg_n ? w_big_neg : w_big_pos;

    always_comb begin
        if (w_clamp) begin
            w_next = r_neg_n ? VAL_MIN : VAL_MAX;
        end else if (r_neg_n) begin
            w_next = -w_div_rsp.quo[VAL_W-1:0];
        end else begin
            w_next = w_div_rsp.quo[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= r_idx;
                r_out_val   <= (r_idx == '0) ? r_prev : r_cur;
                r_out_sat   <= r_sat;
                r_out_last  <= w_out_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    // a negative order is taken and dropped
                    if (i_in_valid && !i_top_order[TOP_W-1]) begin
                        r_n     <= w_top;
                        r_idx   <= '0;
                        r_prev  <= ONE_VAL;
                        r_cur   <= ONE_VAL - w_xs;
                        r_alpha <= ALPHA_1 - w_xs;
                        r_sat   <= 1'b0;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_out_free) begin
                        if (w_out_last) begin
                            r_state <= S_IDLE;
                        end else if (r_idx == '0) begin
                            r_idx <= ORD_W'(1);
                        end else begin
                            r_amag  <= r_alpha[VAL_W-1] ? -r_alpha : r_alpha;
                            r_cmag  <= r_cur[VAL_W-1] ? -r_cur : r_cur;
                            r_pmag  <= r_prev[VAL_W-1] ? -r_prev : r_prev;
                            r_neg_p <= r_alpha[VAL_W-1] ^ r_cur[VAL_W-1];
                            r_neg_q <= r_prev[VAL_W-1];
                            r_mc    <= '0;
                            r_acc   <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_mc != MUL_PASSES) begin
                        r_prod <= w_prod;
                    end
                    if (r_mc != '0) begin
                        r_acc <= r_acc + w_acc_add;
                    end
                    if (r_mc == MUL_PASSES) begin
                        r_kp    <= KP_W'(r_pmag) * KP_W'(r_idx);
                        r_state <= S_RND;
                    end
                    r_mc <= r_mc + 3'd1;
                end
                S_RND: begin
                    r_pm    <= w_rnd_sum[FRAC_W +: NUM_W];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    // combine with the sign of the product factored out
                    r_m     <= (r_neg_p == r_neg_q) ? w_pm_s - w_kp_s : w_pm_s + w_kp_s;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_neg_n <= r_neg_p ^ r_m[M_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_prev  <= r_cur;
                        r_cur   <= w_next;
                        r_sat   <= r_sat | w_clamp;
                        r_idx   <= r_idx + ORD_W'(1);
                        r_alpha <= r_alpha + ALPHA_INC;
                        r_state <= S_PUT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_order_index = r_out_idx;
    assign o_poly_value  = r_out_val;
    assign o_saturated   = r_out_sat;
    assign o_last        = r_out_last;

    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_sat) |=> r_sat)
        else $error("saturation flag dropped within a run");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide wait");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (r_idx <= r_n))
        else $error("result order beyond the requested order");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_out_last) |=> (r_state == S_IDLE))
        else $error("run continued past its last result");

endmodule

### bench/tb_laguerre_sequence_eval.sv
// Testbench for the Laguerre sequence evaluator: directed and random runs checked per beat.
module tb_laguerre_sequence_eval;
    import lse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ORD_W-1:0] order_idx;
        logic [VAL_W-1:0] value;
        logic             sat;
        logic             last;
    } t_term;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} t_stall_mode;

    localparam logic signed [X_W-1:0] X_MAX  = {1'b0, {(X_W-1){1'b1}}};
    localparam logic signed [X_W-1:0] X_MIN  = {1'b1, {(X_W-1){1'b0}}};
    localparam logic signed [X_W-1:0] X_ONE  = X_W'(1) << 24;
    localparam int                    N_RAND = 230;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [X_W-1:0]   i_arg_x;
    logic signed [TOP_W-1:0] i_top_order;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [ORD_W-1:0]        o_order_index;
    logic signed [VAL_W-1:0] o_poly_value;
    logic                    o_saturated;
    logic                    o_last;

    t_term pending_terms[$];
    int    error_count = 0;
    int    burst_left  = 0;

    laguerre_sequence_eval u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_arg_x       (i_arg_x),
        .i_top_order   (i_top_order),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_order_index (o_order_index),
        .o_poly_value  (o_poly_value),
        .o_saturated   (o_saturated),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 50) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Expand one accepted beat into the terms L0 .. Ln it must produce.
    task automatic predict_sequence(input logic signed [X_W-1:0] arg,
                                    input logic signed [TOP_W-1:0] top);
        logic [VAL_W-1:0] one_mx, alpha, prev, cur, next, ma, mc;
        logic [ACC_W-1:0] prod, kprev, num, mag, quo;
        logic             neg, sat;
        int               n;
        if (top < 0) return;
        n = int'(top);
        if (n > MAX_ORDER) n = MAX_ORDER;
        one_mx = ONE_VAL - ({{(VAL_W-X_W){arg[X_W-1]}}, arg} << X_SHIFT);
        prev = ONE_VAL;
        cur  = one_mx;
        sat  = 1'b0;
        pending_terms.push_back('{ORD_W'(0), ONE_VAL, 1'b0, n == 0});
        if (n == 0) return;
        pending_terms.push_back('{ORD_W'(1), one_mx, 1'b0, n == 1});
        for (int k = 1; k < n; k++) begin
            alpha = (VAL_W'(2 * k) << FRAC_W) + one_mx;
            // alpha * L[k] on magnitudes, rounded half away from zero
            neg  = alpha[VAL_W-1] ^ cur[VAL_W-1];
            ma   = alpha[VAL_W-1] ? -alpha : alpha;
            mc   = cur[VAL_W-1] ? -cur : cur;
            prod = ACC_W'(ma) * ACC_W'(mc);
            prod = (prod + RND_HALF) >> FRAC_W;
            if (neg) prod = -prod;
            kprev = ACC_W'(k) * {{(ACC_W-VAL_W){prev[VAL_W-1]}}, prev};
            num   = prod - kprev;
            // divide by k+1, rounded half away from zero
            neg = num[ACC_W-1];
            mag = neg ? -num : num;
            mag = mag + ACC_W'((k + 1) / 2);
            quo = mag / ACC_W'(k + 1);
            if (neg) quo = -quo;
            if (quo[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){quo[VAL_W-1]}}) begin
                sat  = 1'b1;
                next = quo[ACC_W-1] ? VAL_MIN : VAL_MAX;
            end else begin
                next = quo[VAL_W-1:0];
            end
            pending_terms.push_back('{ORD_W'(k + 1), next, sat, (k + 1) == n});
            prev = cur;
            cur  = next;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_item(input logic signed [X_W-1:0] arg,
                             input logic signed [TOP_W-1:0] top);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid  = 1'b1;
        i_arg_x     = arg;
        i_top_order = top;
        do @(posedge i_clk); while (o_in_stall);
        predict_sequence(arg, top);
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Receiver stall pattern: switch between no stall, coin flips and a fixed duty cycle.
    initial begin
        t_stall_mode mode;
        int          mode_left, phase;
        mode        = STALL_NONE;
        mode_left   = 0;
        phase       = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (mode)
                STALL_NONE:   i_out_stall = 1'b0;
                STALL_RANDOM: i_out_stall = ($urandom_range(0, 1) == 1);
                default:      i_out_stall = (phase % 5) < 3;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_term want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_terms.size() == 0) begin
                report_mismatch($sformatf("beat with nothing pending, order %0d",
                                          o_order_index));
            end else begin
                want = pending_terms.pop_front();
                if (o_order_index !== want.order_idx)
                    report_mismatch($sformatf("order_index %0d, want %0d",
                                              o_order_index, want.order_idx));
                if (o_poly_value !== want.value)
                    report_mismatch($sformatf("order %0d poly_value %h, want %h",
                                              want.order_idx, o_poly_value, want.value));
                if (o_saturated !== want.sat)
                    report_mismatch($sformatf("order %0d saturated %b, want %b",
                                              want.order_idx, o_saturated, want.sat));
                if (o_last !== want.last)
                    report_mismatch($sformatf("order %0d last %b, want %b",
                                              want.order_idx, o_last, want.last));
            end
        end
    end

    task automatic test_start_values();
        send_item('0, 0);
        send_item(X_MAX, 0);
        send_item(X_MIN, 1);
        send_item(X_ONE, 1);
        send_item(-1, 2);
        send_item(X_MIN, 2);
    endtask

    task automatic test_negative_order();
        send_item($urandom(), -1);
        send_item(X_MAX, -64);
        send_item(X_ONE, -33);
        send_item('0, 3);
    endtask

    // Extreme arguments, full order and runs that clamp part way through.
    task automatic test_extremes();
        send_item(X_MAX, 63);
        send_item(X_MIN, 63);
        send_item('0, 63);
        send_item(1, 12);
        send_item(-3 * X_ONE, 20);
        send_item(X_ONE <<< 6, 8);
        send_item(X_ONE <<< 5, 30);
        send_item(-(X_ONE <<< 5), 30);
        send_item(X_ONE, 40);
        send_item(X_MAX, 5);
    endtask

    task automatic test_random();
        logic signed [X_W-1:0]   arg;
        logic signed [TOP_W-1:0] top;
        int                      sent, pick;
        sent = 0;
        while (sent < N_RAND) begin
            case ($urandom_range(0, 3))
                0:       arg = X_W'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
                1:       arg = $urandom();
                2:       arg = X_W'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
                default: begin
                    case ($urandom_range(0, 4))
                        0:       arg = X_MAX;
                        1:       arg = X_MIN;
                        2:       arg = '0;
                        3:       arg = 1;
                        default: arg = -1;
                    endcase
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 8)       top = -TOP_W'($urandom_range(1, 64));
            else if (pick < 70) top = TOP_W'($urandom_range(0, 8));
            else if (pick < 92) top = TOP_W'($urandom_range(9, 30));
            else if (pick < 98) top = TOP_W'($urandom_range(31, 62));
            else                top = TOP_W'(MAX_ORDER);
            send_item(arg, top);
            if (top >= 0) sent++;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_arg_x     = '0;
        i_top_order = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_start_values();
        test_negative_order();
        test_extremes();
        test_random();

        while (pending_terms.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
